/* hw/rtl/tatu_pkg.sv */
// Shared types and constants for the thermistor linearizer pipeline.
package tatu_pkg;

    localparam int LOG_FRAC = 24;                  // fraction bits of the log2 values
    localparam int P_W      = 6;                   // integer part of log2 of a 64-bit word
    localparam int M_W      = 32;                  // normalized mantissa width
    localparam int L2_W     = 31;                  // log2 magnitude width (Q.24)
    localparam int LN_W     = 31;                  // ln magnitude width (Q.24)
    localparam int Q_W      = LN_W + 16;           // dividend / quotient width
    localparam int REM_W    = 32;                  // partial remainder width
    localparam int RAW_W    = 16;                  // widest sample kept for raw mode

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] T_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] T_MIN   = 32'h8000_0000;
    localparam logic [31:0] BETA_RESET = 32'd16777216;

    // configuration register indexes
    localparam logic [1:0] CFG_SENSOR_EN = 2'd0;
    localparam logic [1:0] CFG_ALPHA     = 2'd1;
    localparam logic [1:0] CFG_BETA      = 2'd2;
    localparam logic [1:0] CFG_DIVIDER   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_NO_SENSOR = 2'd1;
    localparam logic [1:0] ST_RAW       = 2'd2;
    localparam logic [1:0] ST_SAT       = 2'd3;

    // how an item is resolved; only K_CALC uses the log / divide datapath
    typedef enum logic [2:0] {
        K_CALC,
        K_NO_SENSOR,
        K_RAW,
        K_DEN_ZERO,
        K_NUM_ZERO
    } t_kind;

    // side information that travels with an item down the chain
    typedef struct packed {
        t_kind              kind;
        logic [RAW_W-1:0]   raw;
        logic               l2_neg;
        logic               ln_zero;
    } t_side;

    // one log cell's data: both logarithms advance side by side
    typedef struct packed {
        logic [M_W-1:0]      m_n;
        logic [M_W-1:0]      m_d;
        logic [LOG_FRAC-1:0] fr_n;
        logic [LOG_FRAC-1:0] fr_d;
        logic [P_W-1:0]      p_n;
        logic [P_W-1:0]      p_d;
    } t_log_data;

    // one divider cell's data: remainder and dividend/quotient shift word
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   dq;
    } t_div_data;

endpackage

/* hw/rtl/thermistor_adc_to_temperature_unit.sv */
// Thermistor ADC sample to Q16.16 temperature: front end, cell chains, output stage.
//
// Input channel (i_in_valid / o_in_ready, payload i_sample) takes one converter
// reading per transfer; output channel (o_out_valid / i_out_ready) returns one
// result per sample: o_temperature (Q16.16) and o_status.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data); write
// only while the block is idle.
//
// Datapath: numerator/denominator products (2 stages), leading-one search and
// normalize (2 stages), a chain of 24 log cells (one fraction bit of log2 per
// cell for both operands), ln2 scaling (3 stages), a chain of 47 restoring
// divider cells (one quotient bit per cell), then the output register.
// Throughput: one sample per cycle while the skid register is free, set by the one-step-per-cell chains.
//
// Reset clears all valid bits and loads the register defaults (sensor off,
// alpha 0, beta 1.0, divider 0). When the receiver stalls, the next finished
// result parks in a skid register; only when that is full does the whole
// pipeline freeze and o_in_ready drop.
module thermistor_adc_to_temperature_unit import tatu_pkg::*; #(
    parameter int ADC_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [ADC_BITS-1:0] i_sample,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_temperature,
    output logic [1:0]          o_status,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data
);

    localparam int NUM_W  = 32 + ADC_BITS;
    localparam int PP_W   = 24 + ADC_BITS;
    localparam int LOG_N  = LOG_FRAC;
    localparam int DIV_N  = Q_W;
    localparam logic [ADC_BITS-1:0] FS = '1;

    // ---------------- configuration registers ----------------
    logic        r_sensor_en;
    logic [47:0] r_alpha;
    logic [31:0] r_beta;
    logic [31:0] r_divider;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_en <= 1'b0;
            r_alpha     <= '0;
            r_beta      <= BETA_RESET;
            r_divider   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SENSOR_EN: r_sensor_en <= i_cfg_data[0];
                CFG_ALPHA:     r_alpha     <= i_cfg_data;
                CFG_BETA:      r_beta      <= i_cfg_data[31:0];
                CFG_DIVIDER:   r_divider   <= i_cfg_data[31:0];
                default:       r_sensor_en <= r_sensor_en;
            endcase
        end
    end

    logic        beta_neg;
    logic [31:0] bmag;
    assign beta_neg = r_beta[31];
    assign bmag     = beta_neg ? (32'd0 - r_beta) : r_beta;   // -2^31 maps to 2^31

    // ---------------- flow control ----------------
    logic r_skid_full;
    logic adv;                     // whole pipeline steps when the skid register is free
    assign adv        = !r_skid_full;
    assign o_in_ready = !r_skid_full;

    logic in_xfer;
    assign in_xfer = i_in_valid && o_in_ready;

    // ---------------- stage 1: classify, products ----------------
    t_kind                kind_in;
    logic [ADC_BITS-1:0]  t_in;
    always_comb begin
        t_in = FS - i_sample;
        if (!r_sensor_en)                                 kind_in = K_NO_SENSOR;
        else if (r_alpha[47] || r_alpha == 48'd0)         kind_in = K_RAW;
        else if (i_sample == FS)                          kind_in = K_DEN_ZERO;
        else if (i_sample == '0 || r_divider == 32'd0)    kind_in = K_NUM_ZERO;
        else                                              kind_in = K_CALC;
    end

    logic             r_s1_valid;
    t_side            r_s1_side;
    logic [NUM_W-1:0] r_s1_num;
    logic [PP_W-1:0]  r_s1_pp_lo, r_s1_pp_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else if (adv) r_s1_valid <= in_xfer;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_side.kind    <= kind_in;
            r_s1_side.raw     <= RAW_W'(i_sample);
            r_s1_side.l2_neg  <= 1'b0;
            r_s1_side.ln_zero <= 1'b0;
            r_s1_num   <= NUM_W'(r_divider) * NUM_W'(i_sample);
            r_s1_pp_lo <= PP_W'(r_alpha[23:0]) * PP_W'(t_in);
            r_s1_pp_hi <= PP_W'(r_alpha[47:24]) * PP_W'(t_in);
        end
    end

    // ---------------- stage 2: denominator sum ----------------
    logic        r_s2_valid;
    t_side       r_s2_side;
    logic [63:0] r_s2_num, r_s2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_valid <= 1'b0;
        else if (adv) r_s2_valid <= r_s1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_side <= r_s1_side;
            r_s2_num  <= 64'(r_s1_num);
            r_s2_den  <= 64'(r_s1_pp_lo) + (64'(r_s1_pp_hi) << 24);
        end
    end

    // ---------------- stage 3: leading-one search ----------------
    function automatic logic [P_W-1:0] f_msb(input logic [63:0] v);
        logic [P_W-1:0] p;
        p = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = P_W'(i);
        end
        return p;
    endfunction

    logic           r_s3_valid;
    t_side          r_s3_side;
    logic [63:0]    r_s3_num, r_s3_den;
    logic [P_W-1:0] r_s3_p_n, r_s3_p_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_valid <= 1'b0;
        else if (adv) r_s3_valid <= r_s2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_side <= r_s2_side;
            r_s3_num  <= r_s2_num;
            r_s3_den  <= r_s2_den;
            r_s3_p_n  <= f_msb(r_s2_num);
            r_s3_p_d  <= f_msb(r_s2_den);
        end
    end

    // ---------------- stage 4: normalize to [2^31, 2^32) ----------------
    logic [63:0] sh_n, sh_d;
    assign sh_n = r_s3_num << (P_W'(63) - r_s3_p_n);
    assign sh_d = r_s3_den << (P_W'(63) - r_s3_p_d);

    logic      r_s4_valid;
    t_side     r_s4_side;
    t_log_data r_s4_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_valid <= 1'b0;
        else if (adv) r_s4_valid <= r_s3_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_side       <= r_s3_side;
            r_s4_data.m_n   <= sh_n[63:32];
            r_s4_data.m_d   <= sh_d[63:32];
            r_s4_data.fr_n  <= '0;
            r_s4_data.fr_d  <= '0;
            r_s4_data.p_n   <= r_s3_p_n;
            r_s4_data.p_d   <= r_s3_p_d;
        end
    end

    // ---------------- log cell chain ----------------
    logic      lg_valid [LOG_N+1];
    t_log_data lg_data  [LOG_N+1];
    t_side     lg_side  [LOG_N+1];

    assign lg_valid[0] = r_s4_valid;
    assign lg_data[0]  = r_s4_data;
    assign lg_side[0]  = r_s4_side;

    for (genvar g = 0; g < LOG_N; g++) begin : g_log
        tatu_log_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (lg_valid[g]),
            .i_data  (lg_data[g]),
            .i_side  (lg_side[g]),
            .o_valid (lg_valid[g+1]),
            .o_data  (lg_data[g+1]),
            .o_side  (lg_side[g+1])
        );
    end

    // ---------------- L1: log2 ratio (+8 for the Q24.8 divider) ----------------
    t_log_data       lg_end;
    logic [L2_W-1:0] l2n, l2d;
    assign lg_end = lg_data[LOG_N];
    assign l2n    = L2_W'({lg_end.p_n, lg_end.fr_n}) + L2_W'(32'd8 << LOG_FRAC);
    assign l2d    = L2_W'({lg_end.p_d, lg_end.fr_d});

    logic            r_l1_valid;
    t_side           r_l1_side;
    logic [L2_W-1:0] r_l1_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_l1_valid <= 1'b0;
        else if (adv) r_l1_valid <= lg_valid[LOG_N];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_l1_side        <= lg_side[LOG_N];
            r_l1_side.l2_neg <= l2n < l2d;
            r_l1_mag         <= (l2n < l2d) ? (l2d - l2n) : (l2n - l2d);
        end
    end

    // ---------------- L2: scale by ln 2 ----------------
    logic        r_l2_valid;
    t_side       r_l2_side;
    logic [62:0] r_l2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_l2_valid <= 1'b0;
        else if (adv) r_l2_valid <= r_l1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_l2_side <= r_l1_side;
            r_l2_prod <= 63'(r_l1_mag) * 63'(LN2_Q32);
        end
    end

    // ---------------- L3: round half up, load divider ----------------
    logic [63:0]     rnd;
    logic [LN_W-1:0] ln_mag;
    assign rnd    = 64'(r_l2_prod) + 64'h8000_0000;
    assign ln_mag = rnd[32+LN_W-1:32];

    logic      r_l3_valid;
    t_side     r_l3_side;
    t_div_data r_l3_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_l3_valid <= 1'b0;
        else if (adv) r_l3_valid <= r_l2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_l3_side         <= r_l2_side;
            r_l3_side.ln_zero <= ln_mag == '0;
            r_l3_data.rem     <= '0;
            r_l3_data.dq      <= {ln_mag, 16'd0};
        end
    end

    // ---------------- divider cell chain ----------------
    logic      dv_valid [DIV_N+1];
    t_div_data dv_data  [DIV_N+1];
    t_side     dv_side  [DIV_N+1];

    assign dv_valid[0] = r_l3_valid;
    assign dv_data[0]  = r_l3_data;
    assign dv_side[0]  = r_l3_side;

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        tatu_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (adv),
            .i_valid   (dv_valid[g]),
            .i_data    (dv_data[g]),
            .i_side    (dv_side[g]),
            .i_divisor (bmag),
            .o_valid   (dv_valid[g+1]),
            .o_data    (dv_data[g+1]),
            .o_side    (dv_side[g+1])
        );
    end

    // ---------------- result selection ----------------
    t_side          fin_side;
    logic [Q_W-1:0] q;
    logic           t_neg;
    logic [31:0]    res_temp;
    logic [1:0]     res_status;

    assign fin_side = dv_side[DIV_N];
    assign q        = dv_data[DIV_N].dq;
    assign t_neg    = (!fin_side.l2_neg) != beta_neg;

    always_comb begin
        res_temp   = '0;
        res_status = ST_VALID;
        case (fin_side.kind)
            K_NO_SENSOR: begin
                res_status = ST_NO_SENSOR;
            end
            K_RAW: begin
                res_temp   = {fin_side.raw, 16'd0};
                res_status = ST_RAW;
            end
            K_DEN_ZERO: begin
                res_temp   = beta_neg ? T_MAX : T_MIN;
                res_status = ST_SAT;
            end
            K_NUM_ZERO: begin
                res_temp   = beta_neg ? T_MIN : T_MAX;
                res_status = ST_SAT;
            end
            K_CALC: begin
                if (bmag == 32'd0) begin
                    // flat model: only the sign of -ln x is meaningful
                    res_status = ST_SAT;
                    if (!fin_side.ln_zero) res_temp = fin_side.l2_neg ? T_MAX : T_MIN;
                end else if (q == '0) begin
                    res_temp = '0;
                end else if (t_neg) begin
                    if (q > Q_W'(T_MIN)) begin
                        res_temp   = T_MIN;
                        res_status = ST_SAT;
                    end else begin
                        res_temp = 32'd0 - q[31:0];
                    end
                end else if (q > Q_W'(T_MAX)) begin
                    res_temp   = T_MAX;
                    res_status = ST_SAT;
                end else begin
                    res_temp = q[31:0];
                end
            end
            default: begin
                res_status = ST_SAT;
            end
        endcase
    end

    // ---------------- output register and skid register ----------------
    logic        pipe_v;
    assign pipe_v = dv_valid[DIV_N];

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_temp, n_out_temp;
    logic [1:0]  r_out_status, n_out_status;
    logic        n_skid_full;
    logic [31:0] r_skid_temp, n_skid_temp;
    logic [1:0]  r_skid_status, n_skid_status;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_temp    = r_out_temp;
        n_out_status  = r_out_status;
        n_skid_full   = r_skid_full;
        n_skid_temp   = r_skid_temp;
        n_skid_status = r_skid_status;
        if (!r_out_valid || i_out_ready) begin
            if (r_skid_full) begin
                n_out_valid  = 1'b1;
                n_out_temp   = r_skid_temp;
                n_out_status = r_skid_status;
                n_skid_full  = 1'b0;
            end else begin
                n_out_valid  = pipe_v;
                n_out_temp   = res_temp;
                n_out_status = res_status;
            end
        end else if (!r_skid_full && pipe_v) begin
            n_skid_full   = 1'b1;
            n_skid_temp   = res_temp;
            n_skid_status = res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skid_full <= n_skid_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_temp    <= n_out_temp;
        r_out_status  <= n_out_status;
        r_skid_temp   <= n_skid_temp;
        r_skid_status <= n_skid_status;
    end

    assign o_out_valid   = r_out_valid;
    assign o_temperature = r_out_temp;
    assign o_status      = r_out_status;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid register holds a result while the output is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_skid_full ##1 r_skid_full |-> $past(r_out_valid && !i_out_ready))
        else $error("skid register filled without a stalled output");

    a_no_sensor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_NO_SENSOR |-> r_out_temp == 32'd0)
        else $error("no-sensor result carries a nonzero temperature");

    a_raw_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_RAW |-> r_out_temp[15:0] == 16'd0)
        else $error("raw-mode result has fraction bits set");

endmodule

/* hw/rtl/tatu_log_cell.sv */
// One squaring step of the base-2 logarithm, for numerator and denominator.
module tatu_log_cell import tatu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_log_data i_data,
    input  t_side     i_side,
    output logic      o_valid,
    output t_log_data o_data,
    output t_side     o_side
);

    logic      r_valid;
    t_log_data r_data;
    t_side     r_side;

    logic [63:0]    sq_n, sq_d;
    logic [M_W:0]   h_n, h_d;
    t_log_data      n_data;

    always_comb begin
        sq_n = 64'(i_data.m_n) * 64'(i_data.m_n);
        sq_d = 64'(i_data.m_d) * 64'(i_data.m_d);
        h_n  = sq_n[63:31];
        h_d  = sq_d[63:31];
        n_data      = i_data;
        n_data.m_n  = h_n[M_W] ? h_n[M_W:1] : h_n[M_W-1:0];
        n_data.m_d  = h_d[M_W] ? h_d[M_W:1] : h_d[M_W-1:0];
        n_data.fr_n = {i_data.fr_n[LOG_FRAC-2:0], h_n[M_W]};
        n_data.fr_d = {i_data.fr_d[LOG_FRAC-2:0], h_d[M_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

/* hw/rtl/tatu_div_cell.sv */
// One restoring division step: one quotient bit per cell.
module tatu_div_cell import tatu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_div_data        i_data,
    input  t_side            i_side,
    input  logic [31:0]      i_divisor,
    output logic             o_valid,
    output t_div_data        o_data,
    output t_side            o_side
);

    logic      r_valid;
    t_div_data r_data;
    t_side     r_side;

    logic [REM_W:0] rem_sh, dvs, rem_nx;
    logic           ge;
    t_div_data      n_data;

    always_comb begin
        rem_sh = {i_data.rem, i_data.dq[Q_W-1]};
        dvs    = {1'b0, i_divisor};
        ge     = rem_sh >= dvs;
        rem_nx = ge ? rem_sh - dvs : rem_sh;
        n_data.rem = rem_nx[REM_W-1:0];
        n_data.dq  = {i_data.dq[Q_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the thermistor ADC to temperature unit.
module testbench;
    import tatu_pkg::*;

    localparam int ADC_BITS = 10;
    localparam int FS = (1 << ADC_BITS) - 1;
    localparam int LATENCY = 79;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [31:0] temperature;
        logic [1:0]  status;
    } t_reading;

    // Expected readings in transfer order; compares each result to the oldest one.
    class reading_scoreboard;
        t_reading pending[$];
        int       errors;
        int       checked;

        function void note_sample(t_reading r);
            pending.push_back(r);
        endfunction

        function void check_reading(logic [31:0] temp, logic [1:0] st);
            t_reading e;
            if (pending.size() == 0) begin
                $error("unexpected result: temperature %h status %0d", temp, st);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (temp !== e.temperature) begin
                $error("temperature: expected %h actual %h", e.temperature, temp);
                errors++;
            end
            if (st !== e.status) begin
                $error("status: expected %0d actual %0d", e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ADC_BITS-1:0] i_sample;
    logic                o_out_valid;
    logic                i_out_ready;
    logic signed [31:0]  o_temperature;
    logic [1:0]          o_status;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [47:0]         i_cfg_data;

    thermistor_adc_to_temperature_unit #(.ADC_BITS(ADC_BITS)) DUT (.*);

    // Local copy of the configuration registers.
    logic        cfg_sensor_en;
    logic [47:0] cfg_alpha;
    logic [31:0] cfg_beta;
    logic [31:0] cfg_divider;

    reading_scoreboard sb;
    int  accepted_samples;
    int  idle_cycles;
    bit  quiet_mode;     // no idling on either side in the last stretch
    bit  hold_off;       // long receiver stall requested

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // log2 of a positive word, unsigned Q.24, truncating squaring method
    function automatic logic [63:0] log2_fixed(logic [63:0] v);
        int          p;
        logic [63:0] m;
        logic [63:0] r;
        p = 0;
        while (p < 63 && (v >> (p + 1)) != 0) p++;
        m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
        r = 64'(p) << LOG_FRAC;
        for (int i = LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_reading predict_temperature(logic [ADC_BITS-1:0] s);
        t_reading     r;
        logic         beta_neg;
        logic [31:0]  beta_abs;
        logic [63:0]  bmag, num, den, l2n, l2d, l2mag, ln_mag, q;
        logic [127:0] prod;
        logic         l2neg, tneg;
        beta_neg = cfg_beta[31];
        r.temperature = '0;
        r.status = ST_VALID;
        if (!cfg_sensor_en) begin
            r.status = ST_NO_SENSOR;
            return r;
        end
        if (cfg_alpha[47] || cfg_alpha == 0) begin
            r.temperature = 32'(64'(s) << 16);
            r.status = ST_RAW;
            return r;
        end
        beta_abs = beta_neg ? (32'd0 - cfg_beta) : cfg_beta;
        bmag = 64'(beta_abs);
        if (beta_neg && bmag == 0) bmag = 64'h8000_0000;
        num = 64'(cfg_divider) * 64'(s);
        den = 64'(cfg_alpha) * 64'(FS - s);
        r.status = ST_SAT;
        // infinite log argument
        if (den == 0) begin
            r.temperature = beta_neg ? T_MAX : T_MIN;
            return r;
        end
        // zero log argument
        if (num == 0) begin
            r.temperature = beta_neg ? T_MIN : T_MAX;
            return r;
        end
        l2n = log2_fixed(num) + (64'd8 << LOG_FRAC);
        l2d = log2_fixed(den);
        l2neg = l2n < l2d;
        l2mag = l2neg ? l2d - l2n : l2n - l2d;
        prod = 128'(l2mag) * 128'(LN2_Q32) + (128'd1 << 31);
        ln_mag = 64'(prod >> 32);
        if (bmag == 0) begin
            r.temperature = (ln_mag == 0) ? 32'd0 : (l2neg ? T_MAX : T_MIN);
            return r;
        end
        q = (ln_mag << 16) / bmag;
        tneg = (!l2neg) != beta_neg;
        r.status = ST_VALID;
        if (q == 0) return r;
        if (tneg) begin
            if (q > 64'(T_MIN)) begin
                r.temperature = T_MIN;
                r.status = ST_SAT;
            end else begin
                r.temperature = 32'(64'h1_0000_0000 - q);
            end
        end else if (q > 64'(T_MAX)) begin
            r.temperature = T_MAX;
            r.status = ST_SAT;
        end else begin
            r.temperature = 32'(q);
        end
        return r;
    endfunction

    // Watchdog: counts cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results pending", sb.pending.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Output monitor: results are checked at the transfer edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_reading(o_temperature, o_status);
    end

    // Receiver: random stall bursts, a long hold-off on request, none when quiet.
    initial begin
        int n;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 17);
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 20);
                i_out_ready <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic write_register(logic [1:0] idx, logic [47:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SENSOR_EN: cfg_sensor_en = data[0];
            CFG_ALPHA:     cfg_alpha     = data;
            CFG_BETA:      cfg_beta      = data[31:0];
            CFG_DIVIDER:   cfg_divider   = data[31:0];
            default: ;
        endcase
    endtask

    task automatic set_model(logic en, logic [47:0] alpha, logic [31:0] beta,
                             logic [31:0] divider);
        write_register(CFG_SENSOR_EN, 48'(en));
        write_register(CFG_ALPHA, alpha);
        write_register(CFG_BETA, 48'(beta));
        write_register(CFG_DIVIDER, 48'(divider));
    endtask

    // Waits until every expected reading is back, then for the pipeline depth.
    task automatic drain_pipeline();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offers one sample; valid holds until the transfer, with optional idle gap.
    task automatic send_sample(logic [ADC_BITS-1:0] s);
        int gap;
        if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_sample(predict_temperature(s));
        accepted_samples++;
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly samples drawn from the whole range, with the ends of the range mixed in.
    function automatic logic [ADC_BITS-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ADC_BITS'(FS);
            2: return ADC_BITS'($urandom_range(0, 3));
            3: return ADC_BITS'($urandom_range(FS - 3, FS));
            default: return ADC_BITS'($urandom_range(0, FS));
        endcase
    endfunction

    // Realistic thermistor settings plus occasional extreme register values.
    task automatic random_model();
        logic [47:0] alpha;
        logic [31:0] beta, divider;
        case ($urandom_range(0, 5))
            0: alpha = {16'h0000, 32'($urandom_range(1, 65535))};
            1: alpha = 48'({$urandom, $urandom});
            2: alpha = 48'h7FFF_FFFF_FFFF;
            default: alpha = 48'($urandom_range(1, 200000)) << 16;
        endcase
        case ($urandom_range(0, 5))
            0: beta = $urandom;
            1: beta = 32'($urandom_range(0, 3));
            2: beta = -32'($urandom_range(1, 1 << 22));
            default: beta = 32'($urandom_range(1 << 18, 1 << 23));
        endcase
        case ($urandom_range(0, 4))
            0: divider = $urandom;
            1: divider = 32'($urandom_range(0, 255));
            default: divider = 32'($urandom_range(100, 200000)) << 8;
        endcase
        set_model($urandom_range(0, 7) != 0, alpha, beta, divider);
    endtask

    initial begin
        int n;
        sb = new();
        accepted_samples = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        hold_off = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SENSOR_EN;
        i_cfg_data  <= '0;
        cfg_sensor_en = 1'b0;
        cfg_alpha     = '0;
        cfg_beta      = BETA_RESET;
        cfg_divider   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset defaults give no-sensor status.
        send_sample('0);
        send_sample(ADC_BITS'(FS));
        end_burst();
        drain_pipeline();
        // Raw mode, negative alpha, all sample bits.
        set_model(1'b1, 48'h8000_0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        send_sample(ADC_BITS'(FS));
        send_sample(ADC_BITS'(10'h2AA));
        send_sample(ADC_BITS'(10'h155));
        end_burst();
        drain_pipeline();
        // Normal model: 10k alpha, beta about 0.04, 10k divider.
        set_model(1'b1, 48'(10000) << 16, 32'd671089, 32'(10000) << 8);
        send_sample('0);                   // zero log argument
        send_sample(ADC_BITS'(FS));        // infinite log argument
        send_sample(ADC_BITS'(1));
        send_sample(ADC_BITS'(512));
        send_sample(ADC_BITS'(FS - 1));
        end_burst();
        drain_pipeline();
        // Negative beta, then zero beta, zero divider.
        write_register(CFG_BETA, 48'(32'hFF80_0000));
        send_sample('0);
        send_sample(ADC_BITS'(FS));
        send_sample(ADC_BITS'(300));
        end_burst();
        drain_pipeline();
        write_register(CFG_BETA, 48'(0));
        send_sample(ADC_BITS'(200));
        send_sample(ADC_BITS'(800));
        end_burst();
        drain_pipeline();
        write_register(CFG_DIVIDER, 48'(0));
        send_sample(ADC_BITS'(400));
        end_burst();
        drain_pipeline();
        // Tiny beta forces quotient overflow; max alpha; max beta.
        set_model(1'b1, 48'h7FFF_FFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        send_sample(ADC_BITS'(1));
        send_sample(ADC_BITS'(FS - 1));
        end_burst();
        drain_pipeline();
        write_register(CFG_BETA, 48'(32'h7FFF_FFFF));
        send_sample(ADC_BITS'(7));
        end_burst();
        drain_pipeline();

        // Pressure: receiver holds off while samples keep coming.
        random_model();
        hold_off = 1'b1;
        for (int i = 0; i < 150; i++) send_sample(random_sample());
        end_burst();
        drain_pipeline();

        // Random phases, each with its own register setting.
        while (accepted_samples < 1900) begin
            if (accepted_samples > 1650) quiet_mode = 1'b1;
            random_model();
            n = $urandom_range(20, 80);
            for (int i = 0; i < n; i++) send_sample(random_sample());
            end_burst();
            drain_pipeline();
        end

        $display("covered %0d samples, %0d readings checked, across raw, no-sensor,",
                 accepted_samples, sb.checked);
        $display("saturating and normal settings with both-side stalls");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
